FILE: hdl/qpr_pkg.sv
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared register index codes and command codes for the quaternion point
// rotation core.
// ----------------------------------------------------------------------------
package qpr_pkg;

   // configuration register index
   localparam int CSR_INDEX_WIDTH = 3;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_QUAT_W = csr_index_type'(0);
   localparam csr_index_type CSR_QUAT_X = csr_index_type'(1);
   localparam csr_index_type CSR_QUAT_Y = csr_index_type'(2);
   localparam csr_index_type CSR_QUAT_Z = csr_index_type'(3);

   // point command
   typedef logic command_type;
   localparam command_type CMD_ROTATE    = 1'b0;
   localparam command_type CMD_CONJUGATE = 1'b1;

endpackage

FILE: hdl/qpr_if.sv
// ----------------------------------------------------------------------------
// qpr interfaces
// Valid/ready channels for points in, rotated points out and register writes.
// ----------------------------------------------------------------------------

// point request channel
interface qpr_req_if #(
   parameter int COORD_WIDTH = 32
);
   logic                           valid;
   logic                           ready;
   qpr_pkg::command_type           command;
   logic signed [COORD_WIDTH-1:0]  point_x;
   logic signed [COORD_WIDTH-1:0]  point_y;
   logic signed [COORD_WIDTH-1:0]  point_z;

   modport source (output valid, command, point_x, point_y, point_z, input ready);
   modport sink   (input valid, command, point_x, point_y, point_z, output ready);
endinterface

// rotated point response channel
interface qpr_rsp_if #(
   parameter int COORD_WIDTH = 32
);
   logic                           valid;
   logic                           ready;
   logic signed [COORD_WIDTH-1:0]  rot_x;
   logic signed [COORD_WIDTH-1:0]  rot_y;
   logic signed [COORD_WIDTH-1:0]  rot_z;
   logic                           clipped;

   modport source (output valid, rot_x, rot_y, rot_z, clipped, input ready);
   modport sink   (input valid, rot_x, rot_y, rot_z, clipped, output ready);
endinterface

// register write channel
interface qpr_csr_if #(
   parameter int QUAT_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   qpr_pkg::csr_index_type         index;
   logic [QUAT_WIDTH-1:0]          data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/qpr_csr.sv
// ----------------------------------------------------------------------------
// qpr_csr
// Quaternion component registers, reset to the identity rotation.
// ----------------------------------------------------------------------------
module qpr_csr #(
   parameter int QUAT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   qpr_csr_if.sink                       csr,
   output logic signed [QUAT_WIDTH-1:0]  quat_w,
   output logic signed [QUAT_WIDTH-1:0]  quat_x,
   output logic signed [QUAT_WIDTH-1:0]  quat_y,
   output logic signed [QUAT_WIDTH-1:0]  quat_z
);
   import qpr_pkg::*;

   // one in Q1.(QUAT_WIDTH-2)
   localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(1) << (QUAT_WIDTH - 2);

   logic signed [QUAT_WIDTH-1:0] quat_w_ff, quat_w_in;
   logic signed [QUAT_WIDTH-1:0] quat_x_ff, quat_x_in;
   logic signed [QUAT_WIDTH-1:0] quat_y_ff, quat_y_in;
   logic signed [QUAT_WIDTH-1:0] quat_z_ff, quat_z_in;

   // writes are always taken
   assign csr.ready = 1'b1;

   // register write decode, unknown indexes are dropped
   always_comb begin
      quat_w_in = quat_w_ff;
      quat_x_in = quat_x_ff;
      quat_y_in = quat_y_ff;
      quat_z_in = quat_z_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_QUAT_W: begin
               quat_w_in = signed'(csr.data);
            end
            CSR_QUAT_X: begin
               quat_x_in = signed'(csr.data);
            end
            CSR_QUAT_Y: begin
               quat_y_in = signed'(csr.data);
            end
            CSR_QUAT_Z: begin
               quat_z_in = signed'(csr.data);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_w_ff <= QUAT_ONE;
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
      end else begin
         quat_w_ff <= quat_w_in;
         quat_x_ff <= quat_x_in;
         quat_y_ff <= quat_y_in;
         quat_z_ff <= quat_z_in;
      end
   end

   assign quat_w = quat_w_ff;
   assign quat_x = quat_x_ff;
   assign quat_y = quat_y_ff;
   assign quat_z = quat_z_ff;

   // a write to an unknown index changes nothing
   a_unknown_index_ignored: assert property (@(posedge clock) disable iff (reset)
      (csr.valid && csr.ready && csr.index != CSR_QUAT_W && csr.index != CSR_QUAT_X &&
       csr.index != CSR_QUAT_Y && csr.index != CSR_QUAT_Z)
      |=> ($stable(quat_w_ff) && $stable(quat_x_ff) && $stable(quat_y_ff) &&
           $stable(quat_z_ff)))
      else $error("register changed on write to unknown index");

endmodule

FILE: hdl/qpr_matrix.sv
// ----------------------------------------------------------------------------
// qpr_matrix
// Stages 1 and 2: quaternion pair products, then the rotation matrix entries
// with the conjugate applied by flipping the sign of the w products.
// ----------------------------------------------------------------------------
module qpr_matrix #(
   parameter int COORD_WIDTH = 32,
   parameter int QUAT_WIDTH  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic signed [QUAT_WIDTH-1:0]    quat_w,
   input  logic signed [QUAT_WIDTH-1:0]    quat_x,
   input  logic signed [QUAT_WIDTH-1:0]    quat_y,
   input  logic signed [QUAT_WIDTH-1:0]    quat_z,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  qpr_pkg::command_type            in_command,
   input  logic signed [COORD_WIDTH-1:0]   in_point [3],
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [2*QUAT_WIDTH:0]    out_m [3][3],
   output logic signed [COORD_WIDTH-1:0]   out_point [3]
);
   import qpr_pkg::*;

   localparam int PW = 2 * QUAT_WIDTH;   // pair product
   localparam int MW = PW + 1;           // matrix entry

   logic v1_ff, v1_in, v2_ff, v2_in;
   logic en1, en2;

   command_type                   cmd1_ff;
   logic signed [COORD_WIDTH-1:0] pt1_ff [3];
   logic signed [COORD_WIDTH-1:0] pt2_ff [3];
   logic signed [PW-1:0] wx_ff, wy_ff, wz_ff, xx_ff, xy_ff, xz_ff, yy_ff, yz_ff, zz_ff;
   logic signed [PW-1:0] wx_in, wy_in, wz_in, xx_in, xy_in, xz_in, yy_in, yz_in, zz_in;
   logic signed [MW-1:0] m_ff [3][3];
   logic signed [MW-1:0] m_in [3][3];
   logic signed [MW-1:0] e_wx, e_wy, e_wz, e_xx, e_xy, e_xz, e_yy, e_yz, e_zz;

   // stage enables, a stage moves when empty or when the next one moves
   always_comb begin
      en2   = !v2_ff || out_ready;
      en1   = !v1_ff || en2;
      v1_in = en1 ? in_valid : v1_ff;
      v2_in = en2 ? v1_ff : v2_ff;
   end

   assign in_ready  = en1;
   assign out_valid = v2_ff;

   // stage 1: pair products of the quaternion components
   always_comb begin
      wx_in = quat_w * quat_x;
      wy_in = quat_w * quat_y;
      wz_in = quat_w * quat_z;
      xx_in = quat_x * quat_x;
      xy_in = quat_x * quat_y;
      xz_in = quat_x * quat_z;
      yy_in = quat_y * quat_y;
      yz_in = quat_y * quat_z;
      zz_in = quat_z * quat_z;
   end

   // stage 2: matrix entries, conjugate negates the w terms
   always_comb begin
      e_xx = MW'(xx_ff);
      e_xy = MW'(xy_ff);
      e_xz = MW'(xz_ff);
      e_yy = MW'(yy_ff);
      e_yz = MW'(yz_ff);
      e_zz = MW'(zz_ff);
      if (cmd1_ff == CMD_CONJUGATE) begin
         e_wx = -MW'(wx_ff);
         e_wy = -MW'(wy_ff);
         e_wz = -MW'(wz_ff);
      end else begin
         e_wx = MW'(wx_ff);
         e_wy = MW'(wy_ff);
         e_wz = MW'(wz_ff);
      end
      m_in[0][0] = -(e_yy + e_zz);
      m_in[0][1] = e_xy - e_wz;
      m_in[0][2] = e_wy + e_xz;
      m_in[1][0] = e_wz + e_xy;
      m_in[1][1] = -(e_xx + e_zz);
      m_in[1][2] = e_yz - e_wx;
      m_in[2][0] = e_xz - e_wy;
      m_in[2][1] = e_wx + e_yz;
      m_in[2][2] = -(e_xx + e_yy);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         cmd1_ff <= in_command;
         pt1_ff  <= in_point;
         wx_ff   <= wx_in;
         wy_ff   <= wy_in;
         wz_ff   <= wz_in;
         xx_ff   <= xx_in;
         xy_ff   <= xy_in;
         xz_ff   <= xz_in;
         yy_ff   <= yy_in;
         yz_ff   <= yz_in;
         zz_ff   <= zz_in;
      end
      if (en2 && v1_ff) begin
         m_ff   <= m_in;
         pt2_ff <= pt1_ff;
      end
   end

   assign out_m     = m_ff;
   assign out_point = pt2_ff;

   // squared terms are never negative, so the diagonal never is positive
   a_diag_nonpositive: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (m_ff[0][0] <= 0 && m_ff[1][1] <= 0 && m_ff[2][2] <= 0))
      else $error("matrix diagonal entry is positive");

   // a stalled matrix stage keeps its item
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !out_ready) |=> (v2_ff && $stable(m_ff[0][1]) && $stable(pt2_ff[2])))
      else $error("stalled matrix stage lost its item");

endmodule

FILE: hdl/qpr_mac.sv
// ----------------------------------------------------------------------------
// qpr_mac
// Stages 3 to 5: matrix times point. Each coordinate is split into a signed
// upper half and an unsigned lower half, the partial products are joined,
// and the three terms of each row are summed with the rounding offset.
// ----------------------------------------------------------------------------
module qpr_mac #(
   parameter int COORD_WIDTH = 32,
   parameter int QUAT_WIDTH  = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic signed [2*QUAT_WIDTH:0]                in_m [3][3],
   input  logic signed [COORD_WIDTH-1:0]               in_point [3],
   output logic                                        out_valid,
   input  logic                                        out_ready,
   output logic signed [2*QUAT_WIDTH+COORD_WIDTH+2:0]  out_sum [3],
   output logic signed [COORD_WIDTH-1:0]               out_point [3]
);
   localparam int MW    = 2 * QUAT_WIDTH + 1;
   localparam int LW    = COORD_WIDTH / 2;           // lower half width
   localparam int HW    = COORD_WIDTH - LW;          // upper half width
   localparam int LPW   = MW + LW + 1;               // lower partial product
   localparam int HPW   = MW + HW;                   // upper partial product
   localparam int FW    = MW + COORD_WIDTH;          // full product
   localparam int SW    = FW + 2;                    // row sum
   localparam int QFRAC = QUAT_WIDTH - 2;
   localparam logic signed [SW-1:0] HALF = SW'(1) << (2 * QFRAC - 2);

   logic v3_ff, v3_in, v4_ff, v4_in, v5_ff, v5_in;
   logic en3, en4, en5;

   logic signed [LPW-1:0]         lo_ff [3][3];
   logic signed [LPW-1:0]         lo_in [3][3];
   logic signed [HPW-1:0]         hi_ff [3][3];
   logic signed [HPW-1:0]         hi_in [3][3];
   logic signed [FW-1:0]          pp_ff [3][3];
   logic signed [FW-1:0]          pp_in [3][3];
   logic signed [SW-1:0]          s_ff [3];
   logic signed [SW-1:0]          s_in [3];
   logic signed [COORD_WIDTH-1:0] pt3_ff [3];
   logic signed [COORD_WIDTH-1:0] pt4_ff [3];
   logic signed [COORD_WIDTH-1:0] pt5_ff [3];

   // stage enables
   always_comb begin
      en5   = !v5_ff || out_ready;
      en4   = !v4_ff || en5;
      en3   = !v3_ff || en4;
      v3_in = en3 ? in_valid : v3_ff;
      v4_in = en4 ? v3_ff : v4_ff;
      v5_in = en5 ? v4_ff : v5_ff;
   end

   assign in_ready  = en3;
   assign out_valid = v5_ff;

   // stage 3: partial products on both halves of each coordinate
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            lo_in[i][j] = in_m[i][j] * signed'({1'b0, in_point[j][LW-1:0]});
            hi_in[i][j] = in_m[i][j] * signed'(in_point[j][COORD_WIDTH-1:LW]);
         end
      end
   end

   // stage 4: join the halves into full products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pp_in[i][j] = (FW'(hi_ff[i][j]) <<< LW) + FW'(lo_ff[i][j]);
         end
      end
   end

   // stage 5: row sums plus rounding offset
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s_in[i] = SW'(pp_ff[i][0]) + SW'(pp_ff[i][1]) + SW'(pp_ff[i][2]) + HALF;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en3 && in_valid) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         pt3_ff <= in_point;
      end
      if (en4 && v3_ff) begin
         pp_ff  <= pp_in;
         pt4_ff <= pt3_ff;
      end
      if (en5 && v4_ff) begin
         s_ff   <= s_in;
         pt5_ff <= pt4_ff;
      end
   end

   assign out_sum   = s_ff;
   assign out_point = pt5_ff;

endmodule

FILE: hdl/qpr_sat.sv
// ----------------------------------------------------------------------------
// qpr_sat
// Stage 6: scale the row sums, add the input point and saturate to the
// coordinate range; this stage is the response output register.
// ----------------------------------------------------------------------------
module qpr_sat #(
   parameter int COORD_WIDTH = 32,
   parameter int QUAT_WIDTH  = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic signed [2*QUAT_WIDTH+COORD_WIDTH+2:0]  in_sum [3],
   input  logic signed [COORD_WIDTH-1:0]               in_point [3],
   qpr_rsp_if.source                                   rsp
);
   localparam int SW    = 2 * QUAT_WIDTH + COORD_WIDTH + 3;
   localparam int QFRAC = QUAT_WIDTH - 2;
   localparam int SH    = 2 * QFRAC - 1;
   localparam logic signed [SW-1:0] SAT_MAX = SW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

   logic                          v6_ff, v6_in;
   logic                          en6;
   logic signed [SW-1:0]          t [3];
   logic signed [COORD_WIDTH-1:0] rot_ff [3];
   logic signed [COORD_WIDTH-1:0] rot_in [3];
   logic                          clip_ff, clip_in;

   // output stage enable
   always_comb begin
      en6   = !v6_ff || rsp.ready;
      v6_in = en6 ? in_valid : v6_ff;
   end

   assign in_ready = en6;

   // p + round(2 * M * p), clamped
   always_comb begin
      clip_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         t[i] = SW'(in_point[i]) + (in_sum[i] >>> SH);
         if (t[i] > SAT_MAX) begin
            rot_in[i] = SAT_MAX[COORD_WIDTH-1:0];
            clip_in   = 1'b1;
         end else if (t[i] < SAT_MIN) begin
            rot_in[i] = SAT_MIN[COORD_WIDTH-1:0];
            clip_in   = 1'b1;
         end else begin
            rot_in[i] = t[i][COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v6_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en6 && in_valid) begin
         rot_ff  <= rot_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp.valid   = v6_ff;
   assign rsp.rot_x   = rot_ff[0];
   assign rsp.rot_y   = rot_ff[1];
   assign rsp.rot_z   = rot_ff[2];
   assign rsp.clipped = clip_ff;

endmodule

FILE: hdl/quaternion_point_rotate_core.sv
// ----------------------------------------------------------------------------
// quaternion_point_rotate_core
// Rotates a stream of 3D points by a unit quaternion, or by its conjugate,
// with saturated Q16.16 results and a saturation flag.
//
//   channel  direction  payload                          transfer when
//   req      in         command, point_x/y/z             req.valid && req.ready
//   rsp      out        rot_x/y/z, clipped               rsp.valid && rsp.ready
//   csr      in         index, data (quat_w/x/y/z)       csr.valid && csr.ready
//
// One point per cycle sustained while rsp.ready stays high; six register stages
// (pair products, matrix, partial products, product join, row sums, scale and
// saturate) lie between the request transfer and rsp.valid.
// Each stage stalls only when full and blocked, so bubbles close up under a
// stalled rsp. Reset clears all stage valid bits and loads the identity
// quaternion. csr writes complete in the cycle they are offered.
// ----------------------------------------------------------------------------
module quaternion_point_rotate_core #(
   parameter int COORD_WIDTH = 32,
   parameter int QUAT_WIDTH  = 16
) (
   input  logic       clock,
   input  logic       reset,
   qpr_req_if.sink    req,
   qpr_rsp_if.source  rsp,
   qpr_csr_if.sink    csr
);
   import qpr_pkg::*;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = ~COORD_MAX;

   logic signed [QUAT_WIDTH-1:0]                 quat_w, quat_x, quat_y, quat_z;
   logic signed [COORD_WIDTH-1:0]                req_point [3];
   logic                                         mtx_valid, mtx_ready;
   logic signed [2*QUAT_WIDTH:0]                 mtx_m [3][3];
   logic signed [COORD_WIDTH-1:0]                mtx_point [3];
   logic                                         mac_valid, mac_ready;
   logic signed [2*QUAT_WIDTH+COORD_WIDTH+2:0]   mac_sum [3];
   logic signed [COORD_WIDTH-1:0]                mac_point [3];

   assign req_point[0] = req.point_x;
   assign req_point[1] = req.point_y;
   assign req_point[2] = req.point_z;

   // quaternion registers
   qpr_csr #(
      .QUAT_WIDTH (QUAT_WIDTH)
   ) u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .quat_w (quat_w),
      .quat_x (quat_x),
      .quat_y (quat_y),
      .quat_z (quat_z)
   );

   // products and matrix
   qpr_matrix #(
      .COORD_WIDTH (COORD_WIDTH),
      .QUAT_WIDTH  (QUAT_WIDTH)
   ) u_matrix (
      .clock      (clock),
      .reset      (reset),
      .quat_w     (quat_w),
      .quat_x     (quat_x),
      .quat_y     (quat_y),
      .quat_z     (quat_z),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .in_command (req.command),
      .in_point   (req_point),
      .out_valid  (mtx_valid),
      .out_ready  (mtx_ready),
      .out_m      (mtx_m),
      .out_point  (mtx_point)
   );

   // matrix times point
   qpr_mac #(
      .COORD_WIDTH (COORD_WIDTH),
      .QUAT_WIDTH  (QUAT_WIDTH)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mtx_valid),
      .in_ready  (mtx_ready),
      .in_m      (mtx_m),
      .in_point  (mtx_point),
      .out_valid (mac_valid),
      .out_ready (mac_ready),
      .out_sum   (mac_sum),
      .out_point (mac_point)
   );

   // scale, add and saturate
   qpr_sat #(
      .COORD_WIDTH (COORD_WIDTH),
      .QUAT_WIDTH  (QUAT_WIDTH)
   ) u_sat (
      .clock    (clock),
      .reset    (reset),
      .in_valid (mac_valid),
      .in_ready (mac_ready),
      .in_sum   (mac_sum),
      .in_point (mac_point),
      .rsp      (rsp)
   );

   // a clipped result has at least one coordinate on a bound
   a_clip_on_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.clipped) |->
      (rsp.rot_x == COORD_MAX || rsp.rot_x == COORD_MIN ||
       rsp.rot_y == COORD_MAX || rsp.rot_y == COORD_MIN ||
       rsp.rot_z == COORD_MAX || rsp.rot_z == COORD_MIN))
      else $error("clipped flag set with no coordinate at a bound");

endmodule
